FILE: rtl/core/fed_pkg.sv
// Package for the feedback echo delay: widths, word types, register indexes,
// MAC operation codes, controller states and the round-and-saturate helper.
// No dependencies; the top level and fed_mac import it.
`timescale 1ns / 1ps

package fed_pkg;

  // Sample and channel layout, settled by the stream word fields
  localparam int SAMPLE_W = 16;
  localparam int CHANNELS = 2;
  localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [CH_W-1:0] CH_LAST = CH_W'(CHANNELS - 1);

  // Default store depth in frames per channel
  localparam int MAX_DELAY_FRAMES_DEF = 262144;

  // Configuration register widths
  localparam int DELAY_W    = 19;
  localparam int FEEDBACK_W = 16;
  localparam int MIX_W      = 17;
  localparam int COEF_W     = 20;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  // Fixed-point layout
  localparam int FRAC_W = 16;
  localparam int PROD_W = COEF_W + SAMPLE_W;
  localparam int ACC_W  = PROD_W + 3;
  localparam int STEP_W = 3;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [ACC_W-1:0]    acc_t;

  localparam acc_t ROUND_HALF = acc_t'(1 << (FRAC_W - 1));
  localparam acc_t SAT_HI     = acc_t'((2 ** (SAMPLE_W - 1)) - 1);
  localparam acc_t SAT_LO     = acc_t'(-(2 ** (SAMPLE_W - 1)));

  localparam logic [MIX_W-1:0] MIX_UNITY = MIX_W'(65536);

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DELAY_FRAMES  = 3'd0,
    CFG_FEEDBACK_GAIN = 3'd1,
    CFG_WET_MIX       = 3'd2,
    CFG_LOWPASS_B0    = 3'd3,
    CFG_LOWPASS_B1    = 3'd4,
    CFG_LOWPASS_B2    = 3'd5,
    CFG_LOWPASS_A1    = 3'd6,
    CFG_LOWPASS_A2    = 3'd7
  } cfg_reg_t;

  // Register reset values
  localparam logic [DELAY_W-1:0]    DELAY_FRAMES_RST  = DELAY_W'(24000);
  localparam logic [FEEDBACK_W-1:0] FEEDBACK_GAIN_RST = FEEDBACK_W'(32768);
  localparam logic [MIX_W-1:0]      WET_MIX_RST       = MIX_W'(32768);
  localparam coef_t                 LOWPASS_B0_RST    = coef_t'(65536);
  localparam coef_t                 COEF_ZERO_RST     = coef_t'(0);

  // Stream words
  typedef struct packed {
    sample_t left_sample;
    sample_t right_sample;
  } in_word_t;

  typedef struct packed {
    sample_t left_out;
    sample_t right_out;
  } out_word_t;

  // Products issued for one channel, in issue order
  typedef enum logic [STEP_W-1:0] {
    OP_FB  = 3'd0,
    OP_B1  = 3'd1,
    OP_B2  = 3'd2,
    OP_A1  = 3'd3,
    OP_A2  = 3'd4,
    OP_WET = 3'd5,
    OP_DRY = 3'd6,
    OP_B0  = 3'd7
  } mac_op_t;

  typedef struct packed {
    logic            vld;
    mac_op_t         op;
    logic [CH_W-1:0] ch;
    coef_t           a;
    sample_t         b;
  } mac_req_t;

  typedef struct packed {
    logic            vld;
    mac_op_t         op;
    logic [CH_W-1:0] ch;
    prod_t           prod;
  } mac_rsp_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_READ,
    ST_WAIT,
    ST_CALC,
    ST_DRAIN,
    ST_WRITE,
    ST_OUT
  } fed_state_t;

  // Round to nearest (halves up) at the Q16 point, then clamp to a sample
  function automatic sample_t rnd_sat(input acc_t v);
    acc_t t;
    t = (v + ROUND_HALF) >>> FRAC_W;
    if (t > SAT_HI) begin
      return sample_t'(SAT_HI);
    end else if (t < SAT_LO) begin
      return sample_t'(SAT_LO);
    end
    return sample_t'(t);
  endfunction

endpackage

FILE: rtl/core/fed_stream_if.sv
// Valid/ready stream interface for the feedback echo delay.
// The word type is a parameter; no package dependency.
`timescale 1ns / 1ps

interface fed_stream_if #(
  parameter type word_t = logic
) ();

  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

FILE: rtl/core/feedback_echo_delay.sv
// Stereo feedback echo with a biquad lowpass in the loop: top level.
// Uses fed_pkg, fed_stream_if, fed_ram and fed_mac.
//
//   port      dir  handshake      word
//   in_ch     in   valid/ready    left_sample, right_sample (Q1.15)
//   out_ch    out  valid/ready    left_out, right_out (Q1.15, saturated)
//   cfg_*     in   cfg_we only    cfg_index selects register, cfg_wdata value
//
// One frame at a time; the single shared multiplier issues eight products per
// channel, plus one RAM read and one RAM write. After the delay is shortened
// below the current position, a bit-serial remainder step runs first.
// Reset (rst_n, synchronous) empties the store at once through a fill count:
// entries at or above it read as zero, so there is no clearing pass.
// A stalled output holds its word; the next frame is taken meanwhile.
`timescale 1ns / 1ps

module feedback_echo_delay import fed_pkg::*; #(
  parameter int MAX_DELAY_FRAMES = MAX_DELAY_FRAMES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  fed_stream_if.sink            in_ch,
  fed_stream_if.source          out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int POS_W = $clog2(MAX_DELAY_FRAMES);
  localparam int LEN_W = $clog2(MAX_DELAY_FRAMES + 1);
  localparam int CMP_W = (LEN_W > DELAY_W) ? LEN_W : DELAY_W;
  localparam int CNT_W = $clog2(POS_W);
  localparam int ROW_W = CHANNELS * SAMPLE_W;

  // Configuration registers
  logic [DELAY_W-1:0]    delay_frames_r;
  logic [FEEDBACK_W-1:0] feedback_gain_r;
  logic [MIX_W-1:0]      wet_mix_r;
  coef_t                 b0_r, b1_r, b2_r, a1_r, a2_r;

  // Control state
  fed_state_t      st_r, st_nxt;
  logic [POS_W-1:0] wp_r;
  logic [POS_W-1:0] pos_r;
  logic [LEN_W-1:0] fill_r;
  logic             active_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CH_W-1:0]  ch_r;
  logic [STEP_W-1:0] stp_r;
  logic             out_valid_r;

  // Datapath registers
  logic [LEN_W-1:0] rem_r;
  logic [POS_W-1:0] quo_src_r;
  sample_t          x_r     [CHANNELS];
  sample_t          y_row_r [CHANNELS];
  sample_t          res_r   [CHANNELS];
  sample_t          row_r   [CHANNELS];
  sample_t          xh1_r   [CHANNELS];
  sample_t          xh2_r   [CHANNELS];
  sample_t          yh1_r   [CHANNELS];
  sample_t          yh2_r   [CHANNELS];
  sample_t          x_cur_r;
  sample_t          u_r;
  acc_t             filt_acc_r;
  acc_t             mix_acc_r;
  out_word_t        out_word_r;

  // Combinational signals
  logic [CMP_W-1:0] delay_ext;
  logic [LEN_W-1:0] len;
  logic [MIX_W-1:0] wet_m;
  logic [MIX_W-1:0] dry_m;
  sample_t          in_x [CHANNELS];
  logic             in_zero;
  logic             pass_thru;
  logic             wp_in_range;
  logic [LEN_W:0]   rem_shift;
  logic [LEN_W:0]   rem_new;
  logic             in_ready;
  logic             ram_we;
  logic             out_load;
  logic             accept;
  logic [ROW_W-1:0] ram_wdata;
  logic [ROW_W-1:0] ram_rdata;
  logic             row_valid;
  logic [LEN_W-1:0] pos_inc;
  mac_req_t         req;
  mac_rsp_t         rsp;
  acc_t             prod_ext;
  sample_t          f_val;

  // Take configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_frames_r  <= DELAY_FRAMES_RST;
      feedback_gain_r <= FEEDBACK_GAIN_RST;
      wet_mix_r       <= WET_MIX_RST;
      b0_r            <= LOWPASS_B0_RST;
      b1_r            <= COEF_ZERO_RST;
      b2_r            <= COEF_ZERO_RST;
      a1_r            <= COEF_ZERO_RST;
      a2_r            <= COEF_ZERO_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_DELAY_FRAMES:  delay_frames_r  <= cfg_wdata[DELAY_W-1:0];
        CFG_FEEDBACK_GAIN: feedback_gain_r <= cfg_wdata[FEEDBACK_W-1:0];
        CFG_WET_MIX:       wet_mix_r       <= cfg_wdata[MIX_W-1:0];
        CFG_LOWPASS_B0:    b0_r            <= coef_t'(cfg_wdata[COEF_W-1:0]);
        CFG_LOWPASS_B1:    b1_r            <= coef_t'(cfg_wdata[COEF_W-1:0]);
        CFG_LOWPASS_B2:    b2_r            <= coef_t'(cfg_wdata[COEF_W-1:0]);
        CFG_LOWPASS_A1:    a1_r            <= coef_t'(cfg_wdata[COEF_W-1:0]);
        CFG_LOWPASS_A2:    a2_r            <= coef_t'(cfg_wdata[COEF_W-1:0]);
      endcase
    end
  end

  // Clamp delay length and wet share
  assign delay_ext = CMP_W'(delay_frames_r);

  always_comb begin
    priority if (delay_ext == '0) begin
      len = LEN_W'(1);
    end else if (delay_ext > CMP_W'(MAX_DELAY_FRAMES)) begin
      len = LEN_W'(MAX_DELAY_FRAMES);
    end else begin
      len = delay_ext[LEN_W-1:0];
    end
  end

  assign wet_m = (wet_mix_r > MIX_UNITY) ? MIX_UNITY : wet_mix_r;
  assign dry_m = MIX_UNITY - wet_m;

  // Input word decode
  assign in_x[0]     = in_ch.data.left_sample;
  assign in_x[1]     = in_ch.data.right_sample;
  assign in_zero     = (in_x[0] == '0) && (in_x[1] == '0);
  assign pass_thru   = in_zero && !active_r;
  assign wp_in_range = (LEN_W'(wp_r) < len);
  assign accept      = in_ch.valid && in_ready;

  // One restoring remainder step
  always_comb begin
    rem_shift = {rem_r, quo_src_r[POS_W-1]};
    if (rem_shift >= {1'b0, len}) begin
      rem_new = rem_shift - {1'b0, len};
    end else begin
      rem_new = rem_shift;
    end
  end

  // Next state and handshake outputs
  always_comb begin
    st_nxt   = st_r;
    in_ready = 1'b0;
    ram_we   = 1'b0;
    out_load = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_ch.valid) begin
          priority if (pass_thru) begin
            st_nxt = ST_OUT;
          end else if (wp_in_range) begin
            st_nxt = ST_READ;
          end else begin
            st_nxt = ST_MOD;
          end
        end
      end
      ST_MOD: begin
        if (cnt_r == '0) begin
          st_nxt = ST_READ;
        end
      end
      ST_READ:  st_nxt = ST_WAIT;
      ST_WAIT:  st_nxt = ST_CALC;
      ST_CALC: begin
        if (mac_op_t'(stp_r) == OP_B0 && ch_r == CH_LAST) begin
          st_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: st_nxt = ST_WRITE;
      ST_WRITE: begin
        ram_we = 1'b1;
        st_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load = 1'b1;
          st_nxt   = ST_IDLE;
        end
      end
    endcase
  end

  // Advance the controller and position
  assign pos_inc = LEN_W'(pos_r) + LEN_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      wp_r        <= '0;
      pos_r       <= '0;
      fill_r      <= '0;
      active_r    <= 1'b0;
      cnt_r       <= '0;
      ch_r        <= '0;
      stp_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      unique case (st_r)
        ST_IDLE: begin
          if (accept && !pass_thru) begin
            active_r <= 1'b1;
            pos_r    <= wp_r;
            cnt_r    <= CNT_W'(POS_W - 1);
          end
        end
        ST_MOD: begin
          cnt_r <= cnt_r - CNT_W'(1);
          if (cnt_r == '0) begin
            pos_r <= rem_new[POS_W-1:0];
          end
        end
        ST_WAIT: begin
          ch_r  <= '0;
          stp_r <= '0;
        end
        ST_CALC: begin
          stp_r <= stp_r + STEP_W'(1);
          if (mac_op_t'(stp_r) == OP_B0) begin
            ch_r <= ch_r + CH_W'(1);
          end
        end
        ST_WRITE: begin
          wp_r <= (pos_inc == len) ? '0 : pos_inc[POS_W-1:0];
          if (LEN_W'(pos_r) == fill_r) begin
            fill_r <= pos_inc;
          end
        end
        ST_READ, ST_DRAIN, ST_OUT: begin
        end
      endcase
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Delay store: one row holds every channel of a frame
  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      ram_wdata[c*SAMPLE_W +: SAMPLE_W] = row_r[c];
    end
  end

  fed_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_DELAY_FRAMES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pos_r),
    .wdata (ram_wdata),
    .raddr (pos_r),
    .rdata (ram_rdata)
  );

  // Rows at or above the fill count were never written and read as zero
  assign row_valid = (LEN_W'(pos_r) < fill_r);

  // Issue one product a cycle for the current channel
  always_comb begin
    req.vld = (st_r == ST_CALC);
    req.op  = mac_op_t'(stp_r);
    req.ch  = ch_r;
    unique case (mac_op_t'(stp_r))
      OP_FB: begin
        req.a = coef_t'({{(COEF_W - FEEDBACK_W){1'b0}}, feedback_gain_r});
        req.b = y_row_r[ch_r];
      end
      OP_B1: begin
        req.a = b1_r;
        req.b = xh1_r[ch_r];
      end
      OP_B2: begin
        req.a = b2_r;
        req.b = xh2_r[ch_r];
      end
      OP_A1: begin
        req.a = a1_r;
        req.b = yh1_r[ch_r];
      end
      OP_A2: begin
        req.a = a2_r;
        req.b = yh2_r[ch_r];
      end
      OP_WET: begin
        req.a = coef_t'({{(COEF_W - MIX_W){1'b0}}, wet_m});
        req.b = y_row_r[ch_r];
      end
      OP_DRY: begin
        req.a = coef_t'({{(COEF_W - MIX_W){1'b0}}, dry_m});
        req.b = x_cur_r;
      end
      OP_B0: begin
        req.a = b0_r;
        req.b = u_r;
      end
    endcase
  end

  fed_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  // Accumulate stage
  assign prod_ext = acc_t'(rsp.prod);
  assign f_val    = rnd_sat(filt_acc_r + prod_ext);

  // Frame data, remainder and accumulators
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int c = 0; c < CHANNELS; c++) begin
        x_r[c]   <= in_x[c];
        res_r[c] <= in_x[c];
      end
      rem_r     <= '0;
      quo_src_r <= wp_r;
    end
    if (st_r == ST_MOD) begin
      rem_r     <= rem_new[LEN_W-1:0];
      quo_src_r <= {quo_src_r[POS_W-2:0], 1'b0};
    end
    if (st_r == ST_WAIT) begin
      for (int c = 0; c < CHANNELS; c++) begin
        y_row_r[c] <= row_valid ? sample_t'(ram_rdata[c*SAMPLE_W +: SAMPLE_W]) : '0;
      end
    end
    if (st_r == ST_CALC && mac_op_t'(stp_r) == OP_FB) begin
      x_cur_r <= x_r[ch_r];
    end
    if (rsp.vld) begin
      unique case (rsp.op)
        OP_FB:  u_r        <= rnd_sat(prod_ext + (acc_t'(x_cur_r) <<< FRAC_W));
        OP_B1:  filt_acc_r <= prod_ext;
        OP_B2:  filt_acc_r <= filt_acc_r + prod_ext;
        OP_A1:  filt_acc_r <= filt_acc_r - prod_ext;
        OP_A2:  filt_acc_r <= filt_acc_r - prod_ext;
        OP_WET: mix_acc_r  <= prod_ext;
        OP_DRY: res_r[rsp.ch] <= rnd_sat(mix_acc_r + prod_ext);
        OP_B0:  row_r[rsp.ch] <= f_val;
      endcase
    end
    if (out_load) begin
      out_word_r.left_out  <= res_r[0];
      out_word_r.right_out <= res_r[1];
    end
  end

  // Shift the filter history once a channel's output is known
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        xh1_r[c] <= '0;
        xh2_r[c] <= '0;
        yh1_r[c] <= '0;
        yh2_r[c] <= '0;
      end
    end else if (rsp.vld && rsp.op == OP_B0) begin
      xh2_r[rsp.ch] <= xh1_r[rsp.ch];
      xh1_r[rsp.ch] <= u_r;
      yh2_r[rsp.ch] <= yh1_r[rsp.ch];
      yh1_r[rsp.ch] <= f_val;
    end
  end

  // Drive the streams
  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_word_r;

  // The write position and the read position never pass the fill count
  a_pos_filled: assert property (@(posedge clk) disable iff (!rst_n)
    (LEN_W'(wp_r) <= fill_r) && (LEN_W'(pos_r) <= fill_r))
    else $error("delay position beyond filled region");

  // The fill count only grows
  a_fill_grows: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> fill_r >= $past(fill_r))
    else $error("fill count fell");

  // No product is in flight while a new frame can be taken
  a_mac_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_IDLE) |-> !rsp.vld)
    else $error("multiplier busy in idle");

  // Once active, the echo stays active until reset
  a_active_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |=> active_r)
    else $error("active flag dropped");

endmodule

FILE: rtl/core/fed_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module fed_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write, and register the read data
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/fed_mac.sv
// Shared multiplier of the feedback echo delay: one signed 20 x 16 product
// a cycle, registered together with its operation tag. Uses fed_pkg.
`timescale 1ns / 1ps

module fed_mac import fed_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  mac_req_t req,
  output mac_rsp_t rsp
);

  mac_rsp_t rsp_r;
  prod_t    prod_nxt;

  // Form the product
  always_comb begin
    prod_nxt = $signed(req.a) * $signed(req.b);
  end

  // Register the valid bit with reset, the op, channel and product without
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rsp_r.vld <= 1'b0;
    end else begin
      rsp_r.vld <= req.vld;
    end
    rsp_r.op   <= req.op;
    rsp_r.ch   <= req.ch;
    rsp_r.prod <= prod_nxt;
  end

  assign rsp = rsp_r;

endmodule
